// ===== design/d2csc_pkg.sv =====
// ============================================================================
// d2csc_pkg: shared types and constants for the dense to CSC compressor
// Holds the item structs, register indexes and the classified queue item.
// ============================================================================
package d2csc_pkg;

    localparam int unsigned ROWS_MAX = 1024;
    localparam int unsigned COLS_MAX = 1024;
    localparam int unsigned NZ_MAX   = 1048576;

    localparam logic [62:0] THR_RESET = 63'd4367597403136100796;
    localparam logic [62:0] INF_BITS  = 63'h7FF0000000000000;

    localparam logic [1:0] REG_NUM_ROWS  = 2'd0;
    localparam logic [1:0] REG_NUM_COLS  = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [63:0] elem_bits;
        logic        start_matrix;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] entry_bits;
        logic [9:0]  row_index;
        logic [9:0]  col_index;
        logic [20:0] position;
        logic [10:0] col_count;
        logic        matrix_end;
        logic        saturated;
        logic        last;
    } out_item_t;

    // classified element handed from front to back
    typedef struct packed {
        logic [63:0] elem_bits;
        logic        start_matrix;
        logic        nonzero;
        logic [10:0] rows;
        logic [10:0] cols;
    } cls_item_t;

endpackage

// ===== design/dense_to_csc_sparse_compressor.sv =====
// ============================================================================
// dense_to_csc_sparse_compressor: dense column-major stream to CSC items
// Classifies each element against a threshold and emits nonzero entries
// plus one summary item per column.
// ============================================================================
//
//  channel   dir  handshake             payload
//  in        in   in_valid/in_ready     in_item_t  (elem_bits, start_matrix)
//  out       out  out_valid/out_ready   out_item_t (entry or column summary)
//  cfg       in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
//  One element per cycle sustained while out is ready and no element yields
//  two results; the back stage's output slot sets this. An element yielding
//  both an entry and a summary holds the back until both have gone out.
//  Reset clears counters and loads register defaults; stalls on out back
//  up through the two-entry queue into the input stage.
//
module dense_to_csc_sparse_compressor
    import d2csc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [62:0] cfg_data
);

    logic [10:0] num_rows_reg;
    logic [10:0] num_cols_reg;
    logic [62:0] thr_reg;

    logic      f_valid, f_ready;
    cls_item_t f_item;
    logic      q_valid, q_ready;
    cls_item_t q_item;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= 11'(ROWS_MAX);
            num_cols_reg <= 11'(COLS_MAX);
            thr_reg      <= THR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_NUM_ROWS:  num_rows_reg <= cfg_data[10:0];
                REG_NUM_COLS:  num_cols_reg <= cfg_data[10:0];
                REG_THRESHOLD: thr_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // classify
    d2csc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .num_rows  (num_rows_reg),
        .num_cols  (num_cols_reg),
        .threshold (thr_reg),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls_item  (f_item)
    );

    // decouple
    d2csc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // count and emit
    d2csc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .cls_item  (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== design/d2csc_front.sv =====
// ============================================================================
// d2csc_front: input stage
// Registers the incoming item, classifies it against the threshold.
// ============================================================================
module d2csc_front
    import d2csc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    input  logic [10:0] num_rows,
    input  logic [10:0] num_cols,
    input  logic [62:0] threshold,
    output logic        cls_valid,
    input  logic        cls_ready,
    output cls_item_t   cls_item
);

    logic      valid_reg;
    cls_item_t item_reg;
    cls_item_t item_next;
    logic [62:0] mag;

    assign in_ready = !valid_reg || cls_ready;
    assign mag      = in_item.elem_bits[62:0];

    always_comb
    begin
        item_next.elem_bits    = in_item.elem_bits;
        item_next.start_matrix = in_item.start_matrix;
        item_next.nonzero      = (mag <= INF_BITS) && (mag > threshold);
        // clamp dimensions
        if (num_rows == 11'd0)
            item_next.rows = 11'd1;
        else if (num_rows > 11'(ROWS_MAX))
            item_next.rows = 11'(ROWS_MAX);
        else
            item_next.rows = num_rows;
        if (num_cols == 11'd0)
            item_next.cols = 11'd1;
        else if (num_cols > 11'(COLS_MAX))
            item_next.cols = 11'(COLS_MAX);
        else
            item_next.cols = num_cols;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

    assign cls_valid = valid_reg;
    assign cls_item  = item_reg;

endmodule

// ===== design/d2csc_queue.sv =====
// ============================================================================
// d2csc_queue: two-entry queue between front and back
// Decouples classification from result emission.
// ============================================================================
module d2csc_queue
    import d2csc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  cls_item_t wr_item,
    output logic      rd_valid,
    input  logic      rd_ready,
    output cls_item_t rd_item
);

    cls_item_t  mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_item;
    end

endmodule

// ===== design/d2csc_back.sv =====
// ============================================================================
// d2csc_back: counter and result stage
// Tracks row, column and position, emits entries and column summaries.
// ============================================================================
module d2csc_back
    import d2csc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cls_valid,
    output logic      cls_ready,
    input  cls_item_t cls_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic [9:0]  row_reg, row_next;
    logic [9:0]  col_reg, col_next;
    logic [20:0] pos_reg, pos_next;
    logic [20:0] beg_reg, beg_next;
    logic [10:0] cnt_reg, cnt_next;

    // two result slots: slot0 goes out first
    logic      v0_reg, v1_reg;
    out_item_t r0_reg, r1_reg;
    out_item_t e_item, s_item;

    logic [9:0]  row_c, col_c;
    logic [20:0] pos_c, beg_c, pos_inc;
    logic [10:0] cnt_c, cnt_inc;
    logic        col_done, mat_done, take;

    // take an item when both slots will be empty after this cycle
    assign cls_ready = !v1_reg && (!v0_reg || out_ready);
    assign take      = cls_valid && cls_ready;

    always_comb
    begin
        row_c = cls_item.start_matrix ? 10'd0 : row_reg;
        col_c = cls_item.start_matrix ? 10'd0 : col_reg;
        pos_c = cls_item.start_matrix ? 21'd0 : pos_reg;
        beg_c = cls_item.start_matrix ? 21'd0 : beg_reg;
        cnt_c = cls_item.start_matrix ? 11'd0 : cnt_reg;

        col_done = ({1'b0, row_c} + 11'd1) >= cls_item.rows;
        mat_done = ({1'b0, col_c} + 11'd1) >= cls_item.cols;

        pos_inc = pos_c;
        cnt_inc = cnt_c;
        if (cls_item.nonzero)
        begin
            if (pos_c < 21'(NZ_MAX))
                pos_inc = pos_c + 21'd1;
            if (cnt_c < 11'(ROWS_MAX))
                cnt_inc = cnt_c + 11'd1;
        end

        e_item.kind       = KIND_ENTRY;
        e_item.entry_bits = cls_item.elem_bits;
        e_item.row_index  = row_c;
        e_item.col_index  = col_c;
        e_item.position   = pos_c;
        e_item.col_count  = 11'd0;
        e_item.matrix_end = 1'b0;
        e_item.saturated  = (pos_inc == 21'(NZ_MAX));
        e_item.last       = !col_done;

        s_item.kind       = KIND_SUMMARY;
        s_item.entry_bits = 64'd0;
        s_item.row_index  = 10'd0;
        s_item.col_index  = col_c;
        s_item.position   = beg_c;
        s_item.col_count  = cnt_inc;
        s_item.matrix_end = mat_done;
        s_item.saturated  = (pos_inc == 21'(NZ_MAX));
        s_item.last       = 1'b1;

        row_next = row_c + 10'd1;
        col_next = col_c;
        pos_next = pos_inc;
        cnt_next = cnt_inc;
        beg_next = beg_c;
        if (col_done)
        begin
            row_next = 10'd0;
            cnt_next = 11'd0;
            if (mat_done)
            begin
                col_next = 10'd0;
                pos_next = 21'd0;
            end
            else
                col_next = col_c + 10'd1;
            beg_next = mat_done ? 21'd0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            pos_reg <= '0;
            beg_reg <= '0;
            cnt_reg <= '0;
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
        end
        else if (take)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            pos_reg <= pos_next;
            beg_reg <= beg_next;
            cnt_reg <= cnt_next;
            v0_reg  <= cls_item.nonzero || col_done;
            v1_reg  <= cls_item.nonzero && col_done;
        end
        else if (v0_reg && out_ready)
        begin
            // advance second result into the output slot
            v0_reg <= v1_reg;
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            r0_reg <= cls_item.nonzero ? e_item : s_item;
            r1_reg <= s_item;
        end
        else if (v0_reg && out_ready)
            r0_reg <= r1_reg;
    end

    assign out_valid = v0_reg;
    assign out_item  = r0_reg;

endmodule
